>>> design/cht_pkg.sv
// Shared types, codes and helper functions for the cookie header tokenizer.
package cht_pkg;

	// Scanner states
	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_NAME    = 3'd1,
		ST_EQ      = 3'd2,
		ST_VAL0    = 3'd3,
		ST_VAL     = 3'd4,
		ST_WAITSEM = 3'd5,
		ST_QVAL    = 3'd6,
		ST_QEND    = 3'd7
	} scan_t;

	// Result event codes
	typedef enum logic [2:0] {
		EV_SKIP  = 3'd0,
		EV_NAME  = 3'd1,
		EV_VALUE = 3'd2,
		EV_PAIR  = 3'd3,
		EV_ERROR = 3'd4
	} ev_t;

	// Prefix matcher: 0..6 characters of "Secure" seen, or no match possible
	localparam logic [2:0] MATCH_FULL = 3'd6;
	localparam logic [2:0] MATCH_NONE = 3'd7;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// Result queue geometry
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	// One result item
	typedef struct packed {
		ev_t        event_res;
		logic [7:0] char_out;
		logic       is_attr;
		logic       is_secure;
		logic       run_last;
	} res_t;

	// Up to two results from one byte
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} scan_res_t;

	// Scanner status for observation
	typedef struct packed {
		scan_t state;
		logic  error_hold;
	} scan_stat_t;

	// C-locale whitespace
	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// Advance the "Secure" prefix matcher by one character
	function automatic logic [2:0] match_next(input logic [2:0] m, input logic [7:0] c);
		logic hit;
		case (m)
			3'd0: hit = (c == 8'h53);
			3'd1: hit = (c == 8'h65);
			3'd2: hit = (c == 8'h63);
			3'd3: hit = (c == 8'h75);
			3'd4: hit = (c == 8'h72);
			3'd5: hit = (c == 8'h65);
			default: hit = 1'b0;
		endcase
		return hit ? (m + 3'd1) : MATCH_NONE;
	endfunction

endpackage

>>> design/cht_in_if.sv
// Header byte channel: valid/ready handshake with one byte and an end flag.
interface cht_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       header_end;

	modport source(output valid, ch, header_end, input ready);
	modport sink(input valid, ch, header_end, output ready);
endinterface

>>> design/cht_out_if.sv
// Token result channel: valid/ready handshake with one result item.
interface cht_out_if;
	logic          valid;
	logic          ready;
	cht_pkg::res_t data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

>>> design/cht_scan.sv
// Cookie header scanner: state registers and per-byte result logic.
module cht_scan (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [7:0]             ch,
	input  logic                   last,
	output cht_pkg::scan_res_t     res,
	output cht_pkg::scan_stat_t    stat
);
	import cht_pkg::*;

	scan_t      state_q, state_n;
	logic       attr_q, attr_n;
	logic [2:0] match_q, match_n;
	logic       err_q, err_n;

	// Hold scanner state; advance only on a taken byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			attr_q  <= 1'b0;
			match_q <= 3'd0;
			err_q   <= 1'b0;
		end else if (take) begin
			state_q <= state_n;
			attr_q  <= attr_n;
			match_q <= match_n;
			err_q   <= err_n;
		end
	end

	// Next state and results
	always_comb begin
		logic ws;
		logic secure;
		res_t r0;
		res_t r1;
		logic two;

		ws     = is_ws(ch);
		secure = (match_q == MATCH_FULL);
		state_n = state_q;
		attr_n  = attr_q;
		match_n = match_q;
		err_n   = err_q;
		r0 = '{event_res: EV_SKIP, char_out: 8'd0, is_attr: 1'b0, is_secure: 1'b0,
			run_last: 1'b0};
		r1 = r0;
		two = 1'b0;

		if (!err_q) begin
			case (state_q)
				ST_IDLE: begin
					if (ch == CH_DOLLAR) begin
						attr_n  = 1'b1;
						match_n = 3'd0;
						state_n = ST_NAME;
					end else if (!ws) begin
						attr_n  = 1'b0;
						match_n = match_next(3'd0, ch);
						state_n = ST_NAME;
						r0.event_res = EV_NAME;
						r0.char_out  = ch;
					end
				end
				ST_NAME: begin
					if (ws) begin
						state_n = secure ? ST_WAITSEM : ST_EQ;
					end else if (ch == CH_EQ) begin
						state_n = secure ? ST_WAITSEM : ST_VAL0;
					end else if (ch == CH_SEMI && secure) begin
						state_n = ST_WAITSEM;
					end else begin
						match_n = match_next(match_q, ch);
						r0.event_res = EV_NAME;
						r0.char_out  = ch;
					end
				end
				ST_EQ: begin
					if (ch == CH_EQ) begin
						state_n = ST_VAL0;
					end else if (!ws) begin
						err_n = 1'b1;
						r0.event_res = EV_ERROR;
					end
				end
				ST_VAL0: begin
					if (ch == CH_QUOTE) begin
						state_n = ST_QVAL;
					end else if (!ws) begin
						state_n = ST_VAL;
						r0.event_res = EV_VALUE;
						r0.char_out  = ch;
					end
				end
				ST_VAL: begin
					if (ch == CH_SEMI) begin
						state_n = ST_IDLE;
						r0.event_res = EV_PAIR;
						r0.is_attr   = attr_q;
						r0.is_secure = secure;
					end else begin
						r0.event_res = EV_VALUE;
						r0.char_out  = ch;
					end
				end
				ST_WAITSEM, ST_QEND: begin
					if (ch == CH_SEMI) begin
						state_n = ST_IDLE;
						r0.event_res = EV_PAIR;
						r0.is_attr   = attr_q;
						r0.is_secure = secure;
					end else if (!ws) begin
						err_n = 1'b1;
						r0.event_res = EV_ERROR;
					end
				end
				ST_QVAL: begin
					if (ch == CH_QUOTE) begin
						state_n = ST_QEND;
					end else begin
						r0.event_res = EV_VALUE;
						r0.char_out  = ch;
					end
				end
				default: begin
					state_n = state_q;
				end
			endcase
		end

		// Close the header: pending pair or error, then back to reset values
		if (last) begin
			if (!err_n) begin
				if (state_n == ST_QEND || state_n == ST_VAL || state_n == ST_VAL0) begin
					r1.event_res = EV_PAIR;
					r1.is_attr   = attr_n;
					r1.is_secure = (match_n == MATCH_FULL);
					two = 1'b1;
				end else if (state_n != ST_IDLE) begin
					r1.event_res = EV_ERROR;
					two = 1'b1;
				end
			end
			state_n = ST_IDLE;
			attr_n  = 1'b0;
			match_n = 3'd0;
			err_n   = 1'b0;
		end

		// Mark the last result of this byte
		if (two) begin
			r1.run_last = 1'b1;
		end else begin
			r0.run_last = 1'b1;
		end

		res.two = two;
		res.r0  = r0;
		res.r1  = r1;
	end

	assign stat.state      = state_q;
	assign stat.error_hold = err_q;

endmodule

>>> design/cht_res_fifo.sv
// Result queue: takes one or two results per cycle, hands out one per transfer.
module cht_res_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  cht_pkg::scan_res_t          din,
	input  logic                        pop,
	output cht_pkg::res_t               head,
	output logic [cht_pkg::RQ_AW:0]     level
);
	import cht_pkg::*;

	res_t             mem [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_q, rd_q;
	logic [RQ_AW:0]   level_q;
	logic [1:0]       n_push;

	assign n_push = push ? (din.two ? 2'd2 : 2'd1) : 2'd0;

	// Write the byte's results
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= din.r0;
			if (din.two) begin
				mem[wr_q + RQ_AW'(1)] <= din.r1;
			end
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + RQ_AW'(n_push);
			rd_q    <= rd_q + RQ_AW'(pop);
			level_q <= level_q + (RQ_AW+1)'(n_push) - (RQ_AW+1)'(pop);
		end
	end

	assign head  = mem[rd_q];
	assign level = level_q;

endmodule

>>> design/cookie_header_tokenizer_top.sv
// Top level of the cookie header tokenizer: input register, scanner, result queue.
//
// Takes one Cookie header byte per transfer and sorts it into skip, name
// character, value character, pair done or error, one result per byte, plus
// a second result (pending pair or error) on a byte that ends the header.
// A byte is accepted every cycle as long as results are taken as fast; a
// byte that ends the header with two results occupies the result port with
// them one after the other. A byte passes through the input register and
// then the four-entry result queue before its first result, and the queue's
// single read port sets the output rate at one result per cycle while the
// output is ready. Input ready drops only when the queue has fewer than two free entries.
module cookie_header_tokenizer_top (
	input  logic     clk,
	input  logic     arst_n,
	cht_in_if.sink   hdr,
	cht_out_if.source tok
);
	import cht_pkg::*;

	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             last_s1;
	logic             room;
	logic             take;
	logic             pop;
	logic             accept;
	scan_res_t        sres;
	scan_stat_t       stat;
	logic [RQ_AW:0]   level;

	assign room   = (level <= (RQ_AW+1)'(RQ_DEPTH - 2));
	assign take   = valid_s1 && room;
	assign accept = hdr.valid && hdr.ready;
	assign pop    = tok.valid && tok.ready;

	assign hdr.ready = !valid_s1 || take;

	// Hold the input byte until the scanner takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1   <= hdr.ch;
			last_s1 <= hdr.header_end;
		end
	end

	cht_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.ch     (ch_s1),
		.last   (last_s1),
		.res    (sres),
		.stat   (stat)
	);

	cht_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (take),
		.din    (sres),
		.pop    (pop),
		.head   (tok.data),
		.level  (level)
	);

	assign tok.valid = (level != '0);

	// Queue never holds more than its depth
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= (RQ_AW+1)'(RQ_DEPTH))
		else $error("result queue overflow");

	// A byte that ends the header leaves the scanner in its reset state
	a_end_reset: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_s1 |=> (stat.state == ST_IDLE) && !stat.error_hold)
		else $error("scanner not reset after header end");

	// While an error is held the scanner state stays put until the header ends
	a_err_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		stat.error_hold && !(take && last_s1) |=> $stable(stat.state))
		else $error("scanner state moved while error held");

	// A byte with no room in the queue is not taken
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> level <= (RQ_AW+1)'(RQ_DEPTH - 2))
		else $error("byte taken without queue room");

endmodule
